[hdl/rtt_pkg.sv]
// ----------------------------------------------------------------------------
// rtt_pkg
// Types, codes and constants shared by the retransmit timer table modules.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  localparam logic [15:0] ACK_PERIOD_RST = 16'd200;
  localparam logic [7:0]  ACK_RETRY_RST  = 8'd5;

  // configuration register indexes
  localparam logic [7:0] CFG_IDX_PERIOD = 8'd0;
  localparam logic [7:0] CFG_IDX_RETRY  = 8'd1;

  // request types
  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_ACK    = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // message kinds
  localparam logic [1:0] KIND_NEW   = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // result events
  localparam logic [2:0] EV_SENT      = 3'd0;
  localparam logic [2:0] EV_RESENT    = 3'd1;
  localparam logic [2:0] EV_DROPPED   = 3'd2;
  localparam logic [2:0] EV_MATCHED   = 3'd3;
  localparam logic [2:0] EV_UNMATCHED = 3'd4;
  localparam logic [2:0] EV_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  msg_kind;
    logic [31:0] msg_id;
    logic [15:0] resend_period;
    logic [7:0]  retry_budget;
    logic [15:0] dest_handle;
    logic [15:0] payload_handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] out_msg_id;
    logic [1:0]  out_kind;
    logic [15:0] out_dest;
    logic [15:0] out_payload;
    logic        last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  req;
    logic [1:0]  kind;
    logic [31:0] msg_id;
    logic [15:0] period;
    logic [7:0]  retries;
    logic [15:0] dest;
    logic [15:0] payload;
  } cmd_t;

  // one table entry
  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  kind;
    logic [31:0] deadline;
    logic [15:0] period;
    logic [7:0]  retries;
    logic [15:0] dest;
    logic [15:0] payload;
  } entry_t;

endpackage

[hdl/rtt_fifo.sv]
// ----------------------------------------------------------------------------
// rtt_fifo
// Small synchronous queue of words, first in first out.
// ----------------------------------------------------------------------------
module rtt_fifo #(
  parameter int  DEPTH  = 2,
  parameter type DATA_T = logic [7:0]
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  DATA_T wr_data,
  output logic  full,
  input  logic  rd_en,
  output DATA_T rd_data,
  output logic  empty
);

  localparam int AW = $clog2(DEPTH);

  DATA_T         mem [DEPTH];
  logic [AW:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]   rd_ptr_r, rd_ptr_nxt;
  logic          do_wr, do_rd;

  // status from pointer compare
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                 (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r[AW-1:0]];

  // pointer update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end

endmodule

[hdl/rtt_front.sv]
// ----------------------------------------------------------------------------
// rtt_front
// Accepts request words, holds the ack settings, drops unknown codes and
// resolves the period and retry count of each submit.
// ----------------------------------------------------------------------------
module rtt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              push,
  input  rtt_pkg::in_word_t in_word,
  output logic              full,
  output logic              cmd_push,
  output rtt_pkg::cmd_t     cmd_word,
  input  logic              cmd_full
);

  import rtt_pkg::*;

  logic [15:0] ack_period_r, ack_period_nxt;
  logic [7:0]  ack_retry_r, ack_retry_nxt;
  logic        keep;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    ack_period_nxt = ack_period_r;
    ack_retry_nxt  = ack_retry_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_IDX_PERIOD) begin
        ack_period_nxt = cfg_data;
      end else if (cfg_index == CFG_IDX_RETRY) begin
        ack_retry_nxt = cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_period_r <= ACK_PERIOD_RST;
      ack_retry_r  <= ACK_RETRY_RST;
    end else begin
      ack_period_r <= ack_period_nxt;
      ack_retry_r  <= ack_retry_nxt;
    end
  end

  // classify the request, unknown codes are consumed without a command
  always_comb begin
    unique case (in_word.req_type)
      REQ_SUBMIT: keep = (in_word.msg_kind == KIND_NEW) ||
                         (in_word.msg_kind == KIND_REPLY) ||
                         (in_word.msg_kind == KIND_ACK);
      REQ_ACK, REQ_TICK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  // resolve submit settings
  always_comb begin
    cmd_word.req     = in_word.req_type;
    cmd_word.kind    = in_word.msg_kind;
    cmd_word.msg_id  = in_word.msg_id;
    cmd_word.period  = in_word.resend_period;
    cmd_word.retries = in_word.retry_budget;
    cmd_word.dest    = in_word.dest_handle;
    cmd_word.payload = in_word.payload_handle;
    if (in_word.msg_kind == KIND_ACK) begin
      cmd_word.period  = ack_period_r;
      cmd_word.retries = ack_retry_r;
    end
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && keep;

endmodule

[hdl/rtt_back.sv]
// ----------------------------------------------------------------------------
// rtt_back
// Executes commands against the timer table: stores submits, removes acked
// entries and walks the table on each tick to resend or drop due entries.
// ----------------------------------------------------------------------------
module rtt_back #(
  parameter int TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  rtt_pkg::cmd_t      cmd_word,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output rtt_pkg::out_word_t res_word
);

  import rtt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SUB     = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_ACK_END = 3'd3;
  localparam logic [2:0] ST_HANDLE  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [31:0]            time_r, time_nxt;
  logic [31:0]            next_id_r, next_id_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TABLE_DEPTH-1:0] pend_r, pend_nxt;
  logic [IW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   issue_r, issue_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]          rd_idx_r;
  entry_t                 rd_data_r;
  logic                   found_r, found_nxt;
  logic [IW-1:0]          best_idx_r, best_idx_nxt;
  logic [31:0]            best_age_r, best_age_nxt;
  entry_t                 best_r, best_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [NW-1:0]          n_r, n_nxt;
  logic                   first_r, first_nxt;

  entry_t                 mem [TABLE_DEPTH];
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  entry_t                 mem_wdata;

  logic                   free_found;
  logic [IW-1:0]          free_idx;
  logic [31:0]            sub_id;
  logic [31:0]            diff;
  logic [31:0]            age;
  logic                   due;
  logic                   pend;
  logic                   last_one;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // due test and age of the entry under scan
  assign diff = rd_data_r.deadline - time_r;
  assign age  = time_r - rd_data_r.deadline;
  assign due  = (diff == '0) || diff[31];
  assign pend = first_r ? (valid_r[rd_idx_r] && due) : pend_r[rd_idx_r];
  assign sub_id   = (cmd_r.kind == KIND_NEW) ? next_id_r : cmd_r.msg_id;
  assign last_one = (n_r == NW'(MAX_RESULTS - 1)) || (count_r == CW'(1));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    time_nxt     = time_r;
    next_id_nxt  = next_id_r;
    valid_nxt    = valid_r;
    pend_nxt     = pend_r;
    scan_idx_nxt = scan_idx_r;
    issue_nxt    = issue_r;
    rd_vld_nxt   = 1'b0;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_age_nxt = best_age_r;
    best_nxt     = best_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    first_nxt    = first_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_word     = '0;
    mem_we       = 1'b0;
    mem_waddr    = best_idx_r;
    mem_wdata    = best_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop      = 1'b1;
          cmd_nxt      = cmd_word;
          found_nxt    = 1'b0;
          scan_idx_nxt = '0;
          unique case (cmd_word.req)
            REQ_SUBMIT: state_nxt = ST_SUB;
            REQ_ACK: begin
              state_nxt = ST_SCAN;
              issue_nxt = 1'b1;
            end
            REQ_TICK: begin
              state_nxt = ST_SCAN;
              issue_nxt = 1'b1;
              time_nxt  = time_r + 32'd1;
              first_nxt = 1'b1;
              count_nxt = '0;
              n_nxt     = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SUB: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_word.out_msg_id = sub_id;
          res_word.out_kind   = cmd_r.kind;
          res_word.out_dest   = cmd_r.dest;
          res_word.out_payload = cmd_r.payload;
          res_word.last       = 1'b1;
          if (free_found) begin
            res_word.event_res  = EV_SENT;
            mem_we              = 1'b1;
            mem_waddr           = free_idx;
            mem_wdata.id        = sub_id;
            mem_wdata.kind      = cmd_r.kind;
            mem_wdata.deadline  = time_r + {16'd0, cmd_r.period};
            mem_wdata.period    = cmd_r.period;
            mem_wdata.retries   = cmd_r.retries;
            mem_wdata.dest      = cmd_r.dest;
            mem_wdata.payload   = cmd_r.payload;
            valid_nxt[free_idx] = 1'b1;
            if (cmd_r.kind == KIND_NEW) begin
              next_id_nxt = next_id_r + 32'd1;
            end
          end else begin
            res_word.event_res = EV_FULL;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // issue reads in slot order
        if (issue_r) begin
          rd_vld_nxt = 1'b1;
          if (scan_idx_r == IW'(TABLE_DEPTH - 1)) begin
            issue_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        // evaluate the slot read last cycle
        if (rd_vld_r) begin
          if (cmd_r.req == REQ_ACK) begin
            if (valid_r[rd_idx_r] && (rd_data_r.id == cmd_r.msg_id)) begin
              valid_nxt[rd_idx_r] = 1'b0;
              if (!found_r) begin
                found_nxt = 1'b1;
                best_nxt  = rd_data_r;
              end
            end
          end else begin
            if (first_r) begin
              pend_nxt[rd_idx_r] = pend;
              if (pend) begin
                count_nxt = count_r + 1'b1;
              end
            end
            if (pend && (!found_r || (age > best_age_r))) begin
              found_nxt    = 1'b1;
              best_age_nxt = age;
              best_idx_nxt = rd_idx_r;
              best_nxt     = rd_data_r;
            end
          end
          if (rd_idx_r == IW'(TABLE_DEPTH - 1)) begin
            if (cmd_r.req == REQ_ACK) begin
              state_nxt = ST_ACK_END;
            end else begin
              state_nxt = found_nxt ? ST_HANDLE : ST_IDLE;
            end
          end
        end
      end

      ST_ACK_END: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_word.out_msg_id = cmd_r.msg_id;
          res_word.last       = 1'b1;
          if (found_r) begin
            res_word.event_res   = EV_MATCHED;
            res_word.out_kind    = best_r.kind;
            res_word.out_dest    = best_r.dest;
            res_word.out_payload = best_r.payload;
          end else begin
            res_word.event_res = EV_UNMATCHED;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_HANDLE: begin
        if (!res_full) begin
          res_push             = 1'b1;
          res_word.out_msg_id  = best_r.id;
          res_word.out_kind    = best_r.kind;
          res_word.out_dest    = best_r.dest;
          res_word.out_payload = best_r.payload;
          res_word.last        = last_one;
          pend_nxt[best_idx_r] = 1'b0;
          if (best_r.retries == '0) begin
            res_word.event_res     = EV_DROPPED;
            valid_nxt[best_idx_r]  = 1'b0;
          end else begin
            res_word.event_res = EV_RESENT;
            mem_we             = 1'b1;
            mem_wdata.retries  = best_r.retries - 8'd1;
            mem_wdata.deadline = time_r + {16'd0, best_r.period};
          end
          n_nxt     = n_r + 1'b1;
          count_nxt = count_r - 1'b1;
          if (last_one) begin
            state_nxt = ST_IDLE;
          end else begin
            // next round over the remaining due entries
            state_nxt    = ST_SCAN;
            issue_nxt    = 1'b1;
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
            first_nxt    = 1'b0;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      time_r    <= '0;
      next_id_r <= '0;
      valid_r   <= '0;
      pend_r    <= '0;
      issue_r   <= 1'b0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      count_r   <= '0;
      n_r       <= '0;
      first_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      next_id_r <= next_id_nxt;
      valid_r   <= valid_nxt;
      pend_r    <= pend_nxt;
      issue_r   <= issue_nxt;
      rd_vld_r  <= rd_vld_nxt;
      found_r   <= found_nxt;
      count_r   <= count_nxt;
      n_r       <= n_nxt;
      first_r   <= first_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= scan_idx_r;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    best_r     <= best_nxt;
  end

  // table memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[scan_idx_r];
  end

endmodule

[hdl/retransmit_timer_table.sv]
// ----------------------------------------------------------------------------
// retransmit_timer_table
// Table of outstanding messages with resend deadlines, retry counts and ack
// matching, fed and drained through queue style ports.
// ----------------------------------------------------------------------------
// A submit gives one word. An ack scans the whole table through the single
// read port of the table memory. A tick scans the whole table once when
// nothing is due, and every handled entry costs one full pass over the table
// to find the oldest deadline. Up to 16 entries are handled per tick; the rest
// stay due for the next tick. Requests queue in a two word buffer in front of
// the engine and results in a two word buffer behind it, so either side may
// stall without losing words. Configuration writes are always ready.
module retransmit_timer_table #(
  parameter int TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  input  rtt_pkg::in_word_t  in_word,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output rtt_pkg::out_word_t out_word
);

  import rtt_pkg::*;

  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_in, cmd_out;
  logic      res_push, res_full;
  out_word_t res_word;

  // request classification
  rtt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_word   (in_word),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd_word  (cmd_in),
    .cmd_full  (cmd_full)
  );

  // command queue between front and back
  rtt_fifo #(.DEPTH(2), .DATA_T(cmd_t)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // table engine
  rtt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  // result queue
  rtt_fifo #(.DEPTH(2), .DATA_T(out_word_t)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

  // engine never writes a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result word pushed into full queue");

  // engine never pops an empty command queue
  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command word popped from empty queue");

  // only defined event codes leave the block
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_word.event_res <= EV_FULL))
    else $error("undefined event code on result port");

endmodule
